FILE: design/vrbi_pkg.sv
// Package for the video register bus interface.
// Holds sizes, register addresses, the controller state type and the command struct.
// No dependencies.
`default_nettype none

package vrbi_pkg;

    // Fixed sizes of the stores
    localparam int BANK_BYTES        = 8192;
    localparam int BANK_COUNT_DEF    = 2;
    localparam int SPRITE_BYTES      = 160;
    localparam int COLOR_TABLE_BYTES = 64;

    localparam int OFFS_W = $clog2(BANK_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int CT_AW  = $clog2(COLOR_TABLE_BYTES);

    // Bus map
    localparam logic [15:0] ADDR_OAM_LO = 16'hfe00;
    localparam logic [15:0] ADDR_OAM_HI = 16'hfe9f;
    localparam logic [15:0] ADDR_LCDC   = 16'hff40;
    localparam logic [15:0] ADDR_STAT   = 16'hff41;
    localparam logic [15:0] ADDR_SCY    = 16'hff42;
    localparam logic [15:0] ADDR_SCX    = 16'hff43;
    localparam logic [15:0] ADDR_LY     = 16'hff44;
    localparam logic [15:0] ADDR_LYC    = 16'hff45;
    localparam logic [15:0] ADDR_DMA    = 16'hff46;
    localparam logic [15:0] ADDR_BGP    = 16'hff47;
    localparam logic [15:0] ADDR_OBP0   = 16'hff48;
    localparam logic [15:0] ADDR_OBP1   = 16'hff49;
    localparam logic [15:0] ADDR_WY     = 16'hff4a;
    localparam logic [15:0] ADDR_WX     = 16'hff4b;
    localparam logic [15:0] ADDR_VBK    = 16'hff4f;
    localparam logic [15:0] ADDR_BCPS   = 16'hff68;
    localparam logic [15:0] ADDR_BCPD   = 16'hff69;
    localparam logic [15:0] ADDR_OCPS   = 16'hff6a;
    localparam logic [15:0] ADDR_OCPD   = 16'hff6b;

    localparam logic [2:0] VRAM_TOP  = 3'b100;   // 0x8000-0x9fff
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [7:0] UNMAPPED  = 8'hff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Where the read byte of a finished item comes from
    typedef enum logic [2:0] {
        SRC_REG,
        SRC_VRAM,
        SRC_OAM,
        SRC_BGC,
        SRC_OBJC
    } rd_src_t;

    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // decode, access memories, update registers
        logic load;      // move result into the output register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: design/vrbi_req_if.sv
// Request channel of the video register bus interface: one bus access per item.
// No dependencies.
`default_nettype none

interface vrbi_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [7:0]  current_line;
    logic [1:0]  current_mode;
    logic        oam_blocked;

    modport source (
        output valid, req_type, bus_address, write_byte, current_line,
               current_mode, oam_blocked,
        input  ready
    );
    modport sink (
        input  valid, req_type, bus_address, write_byte, current_line,
               current_mode, oam_blocked,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/vrbi_rsp_if.sv
// Response channel of the video register bus interface: one result item per access.
// No dependencies.
`default_nettype none

interface vrbi_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       status_irq;
    logic       dma_start;
    logic [7:0] dma_page;
    logic       line_reset;
    logic       frame_restart;

    modport source (
        output valid, read_byte, status_irq, dma_start, dma_page, line_reset,
               frame_restart,
        input  ready
    );
    modport sink (
        input  valid, read_byte, status_irq, dma_start, dma_page, line_reset,
               frame_restart,
        output ready
    );
endinterface

`default_nettype wire

FILE: design/vrbi_cfg_if.sv
// Configuration write channel: carries the color model select bit.
// No dependencies.
`default_nettype none

interface vrbi_cfg_if;
    logic valid;
    logic ready;
    logic color_model;

    modport source (output valid, color_model, input ready);
    modport sink   (input valid, color_model, output ready);
endinterface

`default_nettype wire

FILE: design/vrbi_ctrl.sv
// Controller of the video register bus interface: sequences capture, execute, load.
// Depends on vrbi_pkg.
`default_nettype none

module vrbi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vrbi_pkg::ctrl_cmd_t    cmd
);
    import vrbi_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC: cmd.exec = 1'b1;
            ST_DONE: cmd.load = slot_free;
            default: ;
        endcase
    end

    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_EXEC)
        else $error("captured item did not enter execute");

    a_exec_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_DONE && !in_ready)
        else $error("execute not followed by done");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !out_ready |=> state_reg == ST_DONE)
        else $error("result loaded over an untaken one");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output valid without a finished item");

endmodule

`default_nettype wire

FILE: design/vrbi_dpath.sv
// Datapath of the video register bus interface: request latch, decode, registers,
// video/sprite/color memories and the output register. Depends on vrbi_pkg.
`default_nettype none

module vrbi_dpath #(
    parameter int BANK_COUNT = vrbi_pkg::BANK_COUNT_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vrbi_pkg::ctrl_cmd_t cmd,
    input  wire logic                cfg_we,
    input  wire logic                cfg_color_model,
    input  wire logic                req_type,
    input  wire logic [15:0]         bus_address,
    input  wire logic [7:0]          write_byte,
    input  wire logic [7:0]          current_line,
    input  wire logic [1:0]          current_mode,
    input  wire logic                oam_blocked,
    output logic [7:0]               read_byte,
    output logic                     status_irq,
    output logic                     dma_start,
    output logic [7:0]               dma_page,
    output logic                     line_reset,
    output logic                     frame_restart
);
    import vrbi_pkg::*;

    localparam int VDEPTH  = BANK_BYTES * BANK_COUNT;
    localparam int VADDR_W = $clog2(VDEPTH);

    // latched request
    logic        rq_wr_reg;
    logic [15:0] rq_addr_reg;
    logic [7:0]  rq_data_reg;
    logic [7:0]  rq_line_reg;
    logic [1:0]  rq_mode_reg;
    logic        rq_blocked_reg;

    // register file
    logic [7:0]       lcdc_reg,   lcdc_next;
    logic [3:0]       stat_en_reg, stat_en_next;
    logic [7:0]       scy_reg,    scy_next;
    logic [7:0]       scx_reg,    scx_next;
    logic [7:0]       lyc_reg,    lyc_next;
    logic [7:0]       wy_reg,     wy_next;
    logic [7:0]       wx_reg,     wx_next;
    logic [7:0]       bgp_reg,    bgp_next;
    logic [7:0]       obp0_reg,   obp0_next;
    logic [7:0]       obp1_reg,   obp1_next;
    logic             bank_reg,   bank_next;
    logic [CT_AW:0]   bg_idx_reg, bg_idx_next;
    logic [CT_AW:0]   obj_idx_reg, obj_idx_next;
    logic             color_model_reg;

    // pending result of the executed item
    rd_src_t    res_src_reg, res_src_next;
    logic [7:0] res_byte_reg, res_byte_next;
    logic       res_irq_reg, res_irq_next;
    logic       res_dstart_reg, res_dstart_next;
    logic [7:0] res_dpage_reg, res_dpage_next;
    logic       res_lreset_reg, res_lreset_next;
    logic       res_frestart_reg, res_frestart_next;

    // memories
    logic [7:0] vmem [VDEPTH];
    logic [7:0] smem [SPRITE_BYTES];
    logic [7:0] bgc_mem [COLOR_TABLE_BYTES];
    logic [7:0] objc_mem [COLOR_TABLE_BYTES];
    logic [7:0] vmem_rd_reg, smem_rd_reg, bgc_rd_reg, objc_rd_reg;

    logic               is_vram, is_oam, wr_en;
    logic               bank_eff;
    logic [VADDR_W-1:0] vaddr;
    logic [SPR_AW-1:0]  saddr;
    logic               vram_we, oam_we, bgc_we, objc_we;
    logic [7:0]         final_byte;

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rq_wr_reg      <= req_type;
            rq_addr_reg    <= bus_address;
            rq_data_reg    <= write_byte;
            rq_line_reg    <= current_line;
            rq_mode_reg    <= current_mode;
            rq_blocked_reg <= oam_blocked;
        end
    end

    // decode
    assign is_vram  = rq_addr_reg[15:13] == VRAM_TOP;
    assign is_oam   = rq_addr_reg >= ADDR_OAM_LO && rq_addr_reg <= ADDR_OAM_HI;
    assign wr_en    = cmd.exec && rq_wr_reg;
    assign bank_eff = (BANK_COUNT > 1) ? bank_reg : 1'b0;
    assign vaddr    = VADDR_W'({bank_eff, rq_addr_reg[OFFS_W-1:0]});
    assign saddr    = rq_addr_reg[SPR_AW-1:0];
    assign vram_we  = wr_en && is_vram;
    assign oam_we   = wr_en && is_oam && !rq_blocked_reg;
    assign bgc_we   = wr_en && rq_addr_reg == ADDR_BCPD;
    assign objc_we  = wr_en && rq_addr_reg == ADDR_OCPD;

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vmem[vaddr] <= rq_data_reg;
        if (cmd.exec)
            vmem_rd_reg <= vmem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (oam_we)
            smem[saddr] <= rq_data_reg;
        if (cmd.exec)
            smem_rd_reg <= smem[saddr];
    end

    always_ff @(posedge clk)
    begin
        if (bgc_we)
            bgc_mem[bg_idx_reg[CT_AW-1:0]] <= rq_data_reg;
        if (cmd.exec)
            bgc_rd_reg <= bgc_mem[bg_idx_reg[CT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (objc_we)
            objc_mem[obj_idx_reg[CT_AW-1:0]] <= rq_data_reg;
        if (cmd.exec)
            objc_rd_reg <= objc_mem[obj_idx_reg[CT_AW-1:0]];
    end

    // register updates and result of one access
    always_comb
    begin
        lcdc_next    = lcdc_reg;
        stat_en_next = stat_en_reg;
        scy_next     = scy_reg;
        scx_next     = scx_reg;
        lyc_next     = lyc_reg;
        wy_next      = wy_reg;
        wx_next      = wx_reg;
        bgp_next     = bgp_reg;
        obp0_next    = obp0_reg;
        obp1_next    = obp1_reg;
        bank_next    = bank_reg;
        bg_idx_next  = bg_idx_reg;
        obj_idx_next = obj_idx_reg;

        res_src_next      = SRC_REG;
        res_byte_next     = UNMAPPED;
        res_irq_next      = 1'b0;
        res_dstart_next   = 1'b0;
        res_dpage_next    = 8'h00;
        res_lreset_next   = 1'b0;
        res_frestart_next = 1'b0;

        if (!rq_wr_reg)
        begin
            if (is_vram)
                res_src_next = SRC_VRAM;
            else if (is_oam)
            begin
                if (!rq_blocked_reg)
                    res_src_next = SRC_OAM;
            end
            else
            begin
                case (rq_addr_reg)
                    ADDR_LCDC: res_byte_next = lcdc_reg;
                    ADDR_STAT: res_byte_next = {1'b0, stat_en_reg,
                                                rq_line_reg == lyc_reg, rq_mode_reg};
                    ADDR_SCY:  res_byte_next = scy_reg;
                    ADDR_SCX:  res_byte_next = scx_reg;
                    ADDR_LY:   res_byte_next = rq_line_reg;
                    ADDR_LYC:  res_byte_next = lyc_reg;
                    ADDR_BGP:  res_byte_next = bgp_reg;
                    ADDR_OBP0: res_byte_next = obp0_reg;
                    ADDR_OBP1: res_byte_next = obp1_reg;
                    ADDR_WY:   res_byte_next = wy_reg;
                    ADDR_WX:   res_byte_next = wx_reg;
                    ADDR_VBK:  res_byte_next = {7'b0, bank_reg};
                    ADDR_BCPS: res_byte_next = {bg_idx_reg[CT_AW], 1'b0,
                                                bg_idx_reg[CT_AW-1:0]};
                    ADDR_BCPD: res_src_next  = SRC_BGC;
                    ADDR_OCPS: res_byte_next = {obj_idx_reg[CT_AW], 1'b0,
                                                obj_idx_reg[CT_AW-1:0]};
                    ADDR_OCPD: res_src_next  = SRC_OBJC;
                    default:   res_byte_next = UNMAPPED;
                endcase
            end
        end
        else
        begin
            res_byte_next = 8'h00;
            if (!is_vram && !is_oam)
            begin
                case (rq_addr_reg)
                    ADDR_LCDC:
                    begin
                        // display switched on: restart the frame
                        if (!lcdc_reg[7] && rq_data_reg[7])
                        begin
                            res_frestart_next = 1'b1;
                            res_lreset_next   = 1'b1;
                        end
                        lcdc_next = rq_data_reg;
                    end
                    ADDR_STAT:
                    begin
                        stat_en_next = rq_data_reg[6:3];
                        // monochrome quirk: status write during vblank raises the irq
                        res_irq_next = !color_model_reg && rq_mode_reg == MODE_VBLANK;
                    end
                    ADDR_SCY:  scy_next = rq_data_reg;
                    ADDR_SCX:  scx_next = rq_data_reg;
                    ADDR_LY:   res_lreset_next = 1'b1;
                    ADDR_LYC:  lyc_next = rq_data_reg;
                    ADDR_DMA:
                    begin
                        res_dstart_next = 1'b1;
                        res_dpage_next  = rq_data_reg;
                    end
                    ADDR_BGP:  bgp_next  = rq_data_reg;
                    ADDR_OBP0: obp0_next = rq_data_reg;
                    ADDR_OBP1: obp1_next = rq_data_reg;
                    ADDR_WY:   wy_next   = rq_data_reg;
                    ADDR_WX:   wx_next   = rq_data_reg;
                    ADDR_VBK:  bank_next = rq_data_reg[0];
                    ADDR_BCPS: bg_idx_next = {rq_data_reg[7], rq_data_reg[CT_AW-1:0]};
                    ADDR_BCPD:
                    begin
                        if (bg_idx_reg[CT_AW])
                            bg_idx_next = {1'b1, bg_idx_reg[CT_AW-1:0] + CT_AW'(1)};
                    end
                    ADDR_OCPS: obj_idx_next = {rq_data_reg[7], rq_data_reg[CT_AW-1:0]};
                    ADDR_OCPD:
                    begin
                        if (obj_idx_reg[CT_AW])
                            obj_idx_next = {1'b1, obj_idx_reg[CT_AW-1:0] + CT_AW'(1)};
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg    <= '0;
            stat_en_reg <= '0;
            scy_reg     <= '0;
            scx_reg     <= '0;
            lyc_reg     <= '0;
            wy_reg      <= '0;
            wx_reg      <= '0;
            bgp_reg     <= '0;
            obp0_reg    <= '0;
            obp1_reg    <= '0;
            bank_reg    <= 1'b0;
            bg_idx_reg  <= '0;
            obj_idx_reg <= '0;
        end
        else if (wr_en)
        begin
            lcdc_reg    <= lcdc_next;
            stat_en_reg <= stat_en_next;
            scy_reg     <= scy_next;
            scx_reg     <= scx_next;
            lyc_reg     <= lyc_next;
            wy_reg      <= wy_next;
            wx_reg      <= wx_next;
            bgp_reg     <= bgp_next;
            obp0_reg    <= obp0_next;
            obp1_reg    <= obp1_next;
            bank_reg    <= bank_next;
            bg_idx_reg  <= bg_idx_next;
            obj_idx_reg <= obj_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_model_reg <= 1'b0;
        else if (cfg_we)
            color_model_reg <= cfg_color_model;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_src_reg      <= res_src_next;
            res_byte_reg     <= res_byte_next;
            res_irq_reg      <= res_irq_next;
            res_dstart_reg   <= res_dstart_next;
            res_dpage_reg    <= res_dpage_next;
            res_lreset_reg   <= res_lreset_next;
            res_frestart_reg <= res_frestart_next;
        end
    end

    always_comb
    begin
        case (res_src_reg)
            SRC_VRAM: final_byte = vmem_rd_reg;
            SRC_OAM:  final_byte = smem_rd_reg;
            SRC_BGC:  final_byte = bgc_rd_reg;
            SRC_OBJC: final_byte = objc_rd_reg;
            default:  final_byte = res_byte_reg;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_byte     <= final_byte;
            status_irq    <= res_irq_reg;
            dma_start     <= res_dstart_reg;
            dma_page      <= res_dpage_reg;
            line_reset    <= res_lreset_reg;
            frame_restart <= res_frestart_reg;
        end
    end

endmodule

`default_nettype wire

FILE: design/video_register_bus_interface_top.sv
// Top level of the video register bus interface: controller plus datapath.
// Depends on vrbi_pkg, vrbi_req_if, vrbi_rsp_if, vrbi_cfg_if, vrbi_ctrl, vrbi_dpath.
`default_nettype none

// Bus-side register file of the picture unit. Each request item is one CPU read
// or write; each gives exactly one result item (read byte, 0xff for unmapped or
// blocked reads, 0 for writes, plus the status irq, DMA start/page, line reset
// and frame restart pulses). An item is latched, then executed (decode, register
// update, one access to the video, sprite or color memory, whose read data is
// registered), then loaded into the output register. A new item is accepted once
// the previous result sits in the output register, so items do not overlap; the
// load waits while an untaken result still sits there. Memories need no
// clearing pass after reset; their contents are undefined until written.
// color_model is written through the cfg channel, which is always ready, and
// is expected to change only while the block is idle.
module video_register_bus_interface_top #(
    parameter int BANK_COUNT = vrbi_pkg::BANK_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vrbi_req_if.sink  req,
    vrbi_rsp_if.source rsp,
    vrbi_cfg_if.sink  cfg
);
    import vrbi_pkg::*;

    ctrl_cmd_t cmd;
    logic      in_ready;
    logic      out_valid;

    // configuration register is a plain flop, so writes never stall
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    vrbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    vrbi_dpath #(
        .BANK_COUNT (BANK_COUNT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg.valid),
        .cfg_color_model (cfg.color_model),
        .req_type        (req.req_type),
        .bus_address     (req.bus_address),
        .write_byte      (req.write_byte),
        .current_line    (req.current_line),
        .current_mode    (req.current_mode),
        .oam_blocked     (req.oam_blocked),
        .read_byte       (rsp.read_byte),
        .status_irq      (rsp.status_irq),
        .dma_start       (rsp.dma_start),
        .dma_page        (rsp.dma_page),
        .line_reset      (rsp.line_reset),
        .frame_restart   (rsp.frame_restart)
    );

endmodule

`default_nettype wire
